@@ src/tsqa_pkg.sv @@
package tsqa_pkg;

	// widths fixed by the item and register layout
	localparam int unsigned CNT_W = 16;
	localparam int unsigned PSC_W = 8;
	localparam int unsigned AVG_W = 16;

	// result status codes
	localparam logic [1:0] STATUS_AVG     = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
	localparam logic [1:0] STATUS_HOLD    = 2'd2;

	// input kinds
	localparam logic ACTION_START = 1'b0;
	localparam logic ACTION_POLL  = 1'b1;

	// register indexes (byte address 4*index)
	localparam logic [1:0] REG_RELEASE = 2'd0;
	localparam logic [1:0] REG_MIN     = 2'd1;
	localparam logic [1:0] REG_HOLD    = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	// register reset values
	localparam logic [7:0]  RELEASE_RST = 8'd6;
	localparam logic [7:0]  MIN_RST     = 8'd10;
	localparam logic [15:0] HOLD_RST    = 16'd150;
	localparam logic [15:0] TIMEOUT_RST = 16'd3000;

	// saturation limits
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [PSC_W-1:0] PSC_MAX = '1;

	// command to the serial accumulator
	typedef struct packed {
		logic start;
		logic clr;
	} acc_cmd_t;

endpackage

@@ src/tsqa_acc.sv @@
module tsqa_acc #(
	parameter int unsigned RAW_BITS = 16,
	parameter int unsigned SUM_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsqa_pkg::acc_cmd_t   cmd,
	input  logic [RAW_BITS-1:0]  x,
	input  logic [RAW_BITS-1:0]  y,
	output logic [SUM_W-1:0]     sum_x,
	output logic [SUM_W-1:0]     sum_y,
	output logic                 busy
);

	localparam int unsigned STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	logic [SUM_W-1:0]  acc_x_q, acc_y_q;
	logic [SUM_W-1:0]  add_x_q, add_y_q;
	logic              cy_x_q, cy_y_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [1:0]        bit_x, bit_y;

	// one full adder per lane, lsb first
	assign bit_x = {1'b0, acc_x_q[0]} + {1'b0, add_x_q[0]} + {1'b0, cy_x_q};
	assign bit_y = {1'b0, acc_y_q[0]} + {1'b0, add_y_q[0]} + {1'b0, cy_y_q};

	// sequencing of the serial add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + 1'b1;
		end
	end

	// sum and addend shift registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			add_x_q <= '0;
			add_y_q <= '0;
			cy_x_q  <= 1'b0;
			cy_y_q  <= 1'b0;
		end else if (cmd.start) begin
			if (cmd.clr) begin
				acc_x_q <= '0;
				acc_y_q <= '0;
			end
			add_x_q <= SUM_W'(x);
			add_y_q <= SUM_W'(y);
			cy_x_q  <= 1'b0;
			cy_y_q  <= 1'b0;
		end else if (cmd.clr) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (busy_q) begin
			acc_x_q <= {bit_x[0], acc_x_q[SUM_W-1:1]};
			acc_y_q <= {bit_y[0], acc_y_q[SUM_W-1:1]};
			add_x_q <= {1'b0, add_x_q[SUM_W-1:1]};
			add_y_q <= {1'b0, add_y_q[SUM_W-1:1]};
			cy_x_q  <= bit_x[1];
			cy_y_q  <= bit_y[1];
		end
	end

	assign sum_x = acc_x_q;
	assign sum_y = acc_y_q;
	assign busy  = busy_q;

endmodule

@@ src/tsqa_div.sv @@
module tsqa_div #(
	parameter int unsigned RAW_BITS = 16,
	parameter int unsigned SUM_W = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [SUM_W-1:0]                dvd_x,
	input  logic [SUM_W-1:0]                dvd_y,
	input  logic [tsqa_pkg::CNT_W-1:0]      divisor,
	output logic [tsqa_pkg::AVG_W-1:0]      quo_x,
	output logic [tsqa_pkg::AVG_W-1:0]      quo_y,
	output logic                            busy
);

	localparam int unsigned STEP_W = $clog2(SUM_W);
	localparam int unsigned REM_W = tsqa_pkg::CNT_W;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

	logic [SUM_W-1:0]  dx_q, dy_q;
	logic [REM_W-1:0]  rx_q, ry_q;
	logic [REM_W-1:0]  dv_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [REM_W:0]    trial_x, trial_y, diff_x, diff_y;
	logic              ge_x, ge_y;

	// restoring step, one quotient bit per lane per cycle
	assign trial_x = {rx_q, dx_q[SUM_W-1]};
	assign trial_y = {ry_q, dy_q[SUM_W-1]};
	assign ge_x    = trial_x >= {1'b0, dv_q};
	assign ge_y    = trial_y >= {1'b0, dv_q};
	assign diff_x  = trial_x - {1'b0, dv_q};
	assign diff_y  = trial_y - {1'b0, dv_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + 1'b1;
		end
	end

	// dividend shifts out msb first, quotient shifts in at lsb
	always_ff @(posedge clk) begin
		if (start) begin
			dx_q <= dvd_x;
			dy_q <= dvd_y;
			rx_q <= '0;
			ry_q <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			dx_q <= {dx_q[SUM_W-2:0], ge_x};
			dy_q <= {dy_q[SUM_W-2:0], ge_y};
			rx_q <= ge_x ? diff_x[REM_W-1:0] : trial_x[REM_W-1:0];
			ry_q <= ge_y ? diff_y[REM_W-1:0] : trial_y[REM_W-1:0];
		end
	end

	// the average of RAW_BITS-bit samples fits in RAW_BITS bits
	assign quo_x = tsqa_pkg::AVG_W'(dx_q[RAW_BITS-1:0]);
	assign quo_y = tsqa_pkg::AVG_W'(dy_q[RAW_BITS-1:0]);
	assign busy  = busy_q;

endmodule

@@ src/touch_sample_qualifier_averager_core.sv @@
// Touch press qualifier and averager. Each request is a start or one poll of the touch
// controller; a start arms the block, which waits for the panel to be released, sums raw X
// and Y over one press and, once contact has been absent for release_polls polls with at
// least min_samples samples, returns the truncated average (status 0). A timeout (status 1)
// comes when timeout_polls polls have passed since the start, a hold event (status 2) when one
// contact lasts hold_polls polls; avg fields are zero for those. At most one result follows a
// request, and after a result the block is idle until the next start. A start, or a poll that
// adds no sample, leaves the block ready for the next request; a poll that adds a sample
// holds off requests while the bit-serial adder runs over the RAW_BITS+16 bit sums; a poll
// that produces the average holds off requests while the bit-serial restoring divider runs
// and until the result moves into a free output register. Timeout and hold results also
// wait for a free output register. A result waits in the output register while the next
// request is taken. Registers sit at byte addresses 0, 4, 8, 12: release_polls, min_samples,
// hold_polls, timeout_polls.
module touch_sample_qualifier_averager_core #(
	parameter int unsigned RAW_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// poll requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // touched [0], raw_x [16:1], raw_y [32:17], zero fill
	input  logic        s_tuser,   // action [0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // avg_x [15:0], avg_y [31:16]
	output logic [1:0]  m_tuser,   // status [1:0]
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned SUM_W = RAW_BITS + tsqa_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} fsm_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_WAIT = 3'b010,
		PH_ACQ  = 3'b100
	} phase_t;

	fsm_t   fsm_q;
	phase_t phase_q, n_phase;

	logic [7:0]  release_q, min_q;
	logic [15:0] hold_q, timeout_q;

	logic                        in_q, n_in;
	logic [tsqa_pkg::CNT_W-1:0]  pss_q, n_pss, cp_q, n_cp, cp_t, cnt_q, n_cnt, cnt_t;
	logic [tsqa_pkg::PSC_W-1:0]  psc_q, n_psc, psc_t;
	logic                        do_acc, clr_sum, res_v, div_go;
	logic [1:0]                  res_st, pend_st_q;

	logic                        s_action, s_touched, accept, wr_en, emit_go;
	logic [RAW_BITS-1:0]         s_x, s_y;

	tsqa_pkg::acc_cmd_t          acc_cmd;
	logic [SUM_W-1:0]            sum_x, sum_y;
	logic                        acc_busy, div_busy;
	logic [tsqa_pkg::AVG_W-1:0]  quo_x, quo_y;

	logic                        out_v_q;
	logic [1:0]                  out_st_q;
	logic [tsqa_pkg::AVG_W-1:0]  out_x_q, out_y_q;

	// request fields
	assign s_action  = s_tuser;
	assign s_touched = s_tdata[0];
	assign s_x       = s_tdata[RAW_BITS:1];
	assign s_y       = s_tdata[RAW_BITS+16:17];
	assign s_tready  = (fsm_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	// register writes and reads
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= tsqa_pkg::RELEASE_RST;
			min_q     <= tsqa_pkg::MIN_RST;
			hold_q    <= tsqa_pkg::HOLD_RST;
			timeout_q <= tsqa_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				tsqa_pkg::REG_RELEASE: release_q <= pwdata[7:0];
				tsqa_pkg::REG_MIN:     min_q     <= pwdata[7:0];
				tsqa_pkg::REG_HOLD:    hold_q    <= pwdata[15:0];
				tsqa_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tsqa_pkg::REG_RELEASE: prdata = {24'd0, release_q};
			tsqa_pkg::REG_MIN:     prdata = {24'd0, min_q};
			tsqa_pkg::REG_HOLD:    prdata = {16'd0, hold_q};
			tsqa_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:               prdata = '0;
		endcase
	end

	// poll qualification: next counters and the result decision
	always_comb begin
		n_phase = phase_q;
		n_in    = in_q;
		n_pss   = pss_q;
		n_psc   = psc_q;
		n_cp    = cp_q;
		n_cnt   = cnt_q;
		cp_t    = cp_q;
		cnt_t   = cnt_q;
		psc_t   = psc_q;
		do_acc  = 1'b0;
		clr_sum = 1'b0;
		res_v   = 1'b0;
		res_st  = tsqa_pkg::STATUS_AVG;
		div_go  = 1'b0;
		if (s_action == tsqa_pkg::ACTION_START) begin
			n_phase = PH_WAIT;
			n_in    = 1'b0;
			n_pss   = '0;
			n_psc   = '0;
			n_cp    = '0;
			n_cnt   = '0;
			clr_sum = 1'b1;
		end else if (!(phase_q inside {PH_WAIT, PH_ACQ})) begin
			n_phase = PH_IDLE;
		end else if (pss_q >= timeout_q) begin
			res_v  = 1'b1;
			res_st = tsqa_pkg::STATUS_TIMEOUT;
		end else begin
			if (pss_q != tsqa_pkg::CNT_MAX) begin
				n_pss = pss_q + 1'b1;
			end
			if (s_touched) begin
				// contact: fresh contact restarts the press
				if (!in_q) begin
					n_in = 1'b1;
					cp_t = '0;
					if (phase_q == PH_ACQ) begin
						clr_sum = 1'b1;
						cnt_t   = '0;
					end
				end else if (cp_q != tsqa_pkg::CNT_MAX) begin
					cp_t = cp_q + 1'b1;
				end
				n_cp  = cp_t;
				n_psc = '0;
				n_cnt = cnt_t;
				if (phase_q == PH_ACQ && cnt_t != tsqa_pkg::CNT_MAX) begin
					do_acc = 1'b1;
					n_cnt  = cnt_t + 1'b1;
				end
				if (hold_q != '0 && cp_t >= hold_q) begin
					res_v  = 1'b1;
					res_st = tsqa_pkg::STATUS_HOLD;
				end
			end else if (!in_q) begin
				if (phase_q == PH_WAIT) begin
					n_phase = PH_ACQ;
				end
			end else begin
				// no contact during a press: count toward release
				psc_t = (psc_q != tsqa_pkg::PSC_MAX) ? psc_q + 1'b1 : psc_q;
				cp_t  = (cp_q != tsqa_pkg::CNT_MAX) ? cp_q + 1'b1 : cp_q;
				n_psc = psc_t;
				n_cp  = cp_t;
				if (psc_t >= release_q) begin
					n_in  = 1'b0;
					n_psc = '0;
					n_cp  = '0;
					if (phase_q == PH_WAIT) begin
						n_phase = PH_ACQ;
					end else if (cnt_q >= tsqa_pkg::CNT_W'(min_q) && cnt_q != '0) begin
						res_v  = 1'b1;
						res_st = tsqa_pkg::STATUS_AVG;
						div_go = 1'b1;
					end
				end
			end
		end
		// any result ends the run
		if (res_v) begin
			n_phase = PH_IDLE;
			n_in    = 1'b0;
			n_pss   = '0;
			n_psc   = '0;
			n_cp    = '0;
			n_cnt   = '0;
			clr_sum = 1'b1;
			do_acc  = 1'b0;
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			in_q    <= 1'b0;
			pss_q   <= '0;
			psc_q   <= '0;
			cp_q    <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= n_phase;
			in_q    <= n_in;
			pss_q   <= n_pss;
			psc_q   <= n_psc;
			cp_q    <= n_cp;
			cnt_q   <= n_cnt;
		end
	end

	// serial sum and divide units
	assign acc_cmd.start = accept && do_acc;
	assign acc_cmd.clr   = accept && clr_sum;

	tsqa_acc #(
		.RAW_BITS(RAW_BITS),
		.SUM_W(SUM_W)
	) u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(acc_cmd),
		.x(s_x),
		.y(s_y),
		.sum_x(sum_x),
		.sum_y(sum_y),
		.busy(acc_busy)
	);

	tsqa_div #(
		.RAW_BITS(RAW_BITS),
		.SUM_W(SUM_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && div_go),
		.dvd_x(sum_x),
		.dvd_y(sum_y),
		.divisor(cnt_q),
		.quo_x(quo_x),
		.quo_y(quo_y),
		.busy(div_busy)
	);

	// sequencer
	assign emit_go = (fsm_q == ST_EMIT) && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= ST_IDLE;
			pend_st_q <= tsqa_pkg::STATUS_AVG;
		end else begin
			case (fsm_q)
				ST_IDLE: begin
					if (accept) begin
						pend_st_q <= res_st;
						if (div_go) begin
							fsm_q <= ST_DIV;
						end else if (res_v) begin
							fsm_q <= ST_EMIT;
						end else if (do_acc) begin
							fsm_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					if (!acc_busy) begin
						fsm_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						fsm_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						fsm_q <= ST_IDLE;
					end
				end
				default: fsm_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit_go) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_st_q <= pend_st_q;
			if (pend_st_q == tsqa_pkg::STATUS_AVG) begin
				out_x_q <= quo_x;
				out_y_q <= quo_y;
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {out_y_q, out_x_q};

	// requests are taken only with both serial units at rest
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!acc_busy && !div_busy))
		else $error("request taken while a serial unit is busy");

	// an idle run holds no counts
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (pss_q == '0 && cnt_q == '0 && !in_q))
		else $error("run counters not cleared in idle");

	// timeout and hold results carry zero averages
	a_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != tsqa_pkg::STATUS_AVG) |-> (m_tdata == '0))
		else $error("nonzero average on a non-average result");

	// a finished division always goes to the output slot
	a_div_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == ST_DIV && !div_busy) |=> (fsm_q == ST_EMIT))
		else $error("division result dropped");

endmodule

@@ dv/touch_sample_qualifier_averager_core_test.sv @@
`timescale 1ns / 100ps

module touch_sample_qualifier_averager_core_test;

	localparam int unsigned RAW_BITS = 16;
	localparam int unsigned RAW_MASK = (1 << RAW_BITS) - 1;
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned QUIET_LIMIT = 4000;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_ACQ
	} press_phase_t;

	typedef struct packed {
		logic        action;
		logic        touched;
		logic [15:0] raw_x;
		logic [15:0] raw_y;
	} touch_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] avg_x;
		logic [15:0] avg_y;
	} touch_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// requests waiting to be driven, results the tracker says must come
	touch_req_t poll_backlog[$];
	touch_res_t results_due[$];
	int unsigned queued_count;
	int unsigned mismatch_count = 0;

	// shadow of the register file
	logic [7:0]  cfg_release = tsqa_pkg::RELEASE_RST;
	logic [7:0]  cfg_min = tsqa_pkg::MIN_RST;
	logic [15:0] cfg_hold = tsqa_pkg::HOLD_RST;
	logic [15:0] cfg_timeout = tsqa_pkg::TIMEOUT_RST;

	// press tracker state
	press_phase_t trk_phase = PH_IDLE;
	logic        trk_contact = 1'b0;
	logic [31:0] trk_sum_x = '0;
	logic [31:0] trk_sum_y = '0;
	logic [15:0] trk_samples = '0;
	logic [15:0] trk_run_polls = '0;
	logic [7:0]  trk_quiet_polls = '0;
	logic [15:0] trk_contact_len = '0;

	// driver and receiver bookkeeping
	touch_req_t  drive_req;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic [31:0] stall_pattern = '1;
	int unsigned stall_age = 0;
	int unsigned quiet_cycles = 0;
	touch_res_t  seen_res;
	touch_res_t  want_res;

	touch_sample_qualifier_averager_core #(
		.RAW_BITS(RAW_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	function automatic void clear_press_run();
		trk_contact = 1'b0;
		trk_sum_x = '0;
		trk_sum_y = '0;
		trk_samples = '0;
		trk_run_polls = '0;
		trk_quiet_polls = '0;
		trk_contact_len = '0;
	endfunction

	// advance the press tracker by one accepted request
	function automatic void track_request(input touch_req_t rq);
		logic       result_due;
		touch_res_t res;
		result_due = 1'b0;
		res = '{tsqa_pkg::STATUS_AVG, 16'd0, 16'd0};
		if (rq.action == tsqa_pkg::ACTION_START) begin
			trk_phase = PH_WAIT;
			clear_press_run();
		end else if (trk_phase == PH_IDLE) begin
			// poll with nothing armed is dropped
		end else if (trk_run_polls >= cfg_timeout) begin
			result_due = 1'b1;
			res.status = tsqa_pkg::STATUS_TIMEOUT;
		end else begin
			if (trk_run_polls != tsqa_pkg::CNT_MAX)
				trk_run_polls++;
			if (rq.touched) begin
				// fresh contact restarts its length and, once acquiring, the sums
				if (!trk_contact) begin
					trk_contact = 1'b1;
					trk_contact_len = '0;
					if (trk_phase == PH_ACQ) begin
						trk_sum_x = '0;
						trk_sum_y = '0;
						trk_samples = '0;
					end
				end else if (trk_contact_len != tsqa_pkg::CNT_MAX) begin
					trk_contact_len++;
				end
				trk_quiet_polls = '0;
				if (trk_phase == PH_ACQ && trk_samples != tsqa_pkg::CNT_MAX) begin
					trk_sum_x += rq.raw_x & RAW_MASK;
					trk_sum_y += rq.raw_y & RAW_MASK;
					trk_samples++;
				end
				if (cfg_hold != 0 && trk_contact_len >= cfg_hold) begin
					result_due = 1'b1;
					res.status = tsqa_pkg::STATUS_HOLD;
				end
			end else if (!trk_contact) begin
				if (trk_phase == PH_WAIT)
					trk_phase = PH_ACQ;
			end else begin
				if (trk_quiet_polls != tsqa_pkg::PSC_MAX)
					trk_quiet_polls++;
				if (trk_contact_len != tsqa_pkg::CNT_MAX)
					trk_contact_len++;
				// release confirmed
				if (trk_quiet_polls >= cfg_release) begin
					trk_contact = 1'b0;
					trk_quiet_polls = '0;
					trk_contact_len = '0;
					if (trk_phase == PH_WAIT) begin
						trk_phase = PH_ACQ;
					end else if (trk_samples >= cfg_min && trk_samples != 0) begin
						result_due = 1'b1;
						res.avg_x = 16'(trk_sum_x / trk_samples);
						res.avg_y = 16'(trk_sum_y / trk_samples);
					end
				end
			end
		end
		if (result_due) begin
			results_due.push_back(res);
			trk_phase = PH_IDLE;
			clear_press_run();
		end
	endfunction

	// request driver: bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				track_request(drive_req);
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (poll_backlog.size() != 0) begin
					drive_req = poll_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, drive_req.raw_y, drive_req.raw_x, drive_req.touched};
					s_tuser <= drive_req.action;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result ready follows a rotating stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_age == 0) begin
				stall_age = 64;
				case ($urandom_range(3))
					0: stall_pattern = '1;
					1: stall_pattern = $urandom;
					2: stall_pattern = 32'hAAAA_AAAA;
					default: stall_pattern = 32'h0000_FFFF;
				endcase
			end
			stall_age--;
			stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
			m_tready <= stall_pattern[0];
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res = '{m_tuser, m_tdata[15:0], m_tdata[31:16]};
			if (results_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: result mismatch, expected none, actual status %0h avg %0h/%0h",
					$time, seen_res.status, seen_res.avg_x, seen_res.avg_y);
			end else begin
				want_res = results_due.pop_front();
				check_field("status", 32'(want_res.status), 32'(seen_res.status));
				check_field("avg_x", 32'(want_res.avg_x), 32'(seen_res.avg_x));
				check_field("avg_y", 32'(want_res.avg_y), 32'(seen_res.avg_y));
			end
		end
	end

	// watchdog on cycles with no transfer on any port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic read_reg(input logic [1:0] idx, input logic [31:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", want, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			tsqa_pkg::REG_RELEASE: cfg_release = value[7:0];
			tsqa_pkg::REG_MIN: cfg_min = value[7:0];
			tsqa_pkg::REG_HOLD: cfg_hold = value[15:0];
			default: cfg_timeout = value[15:0];
		endcase
		kept = (idx inside {tsqa_pkg::REG_RELEASE, tsqa_pkg::REG_MIN}) ?
			(value & 32'hFF) : (value & 32'hFFFF);
		read_reg(idx, kept);
	endtask

	task automatic apply_settings(input logic [7:0] rel, input logic [7:0] mn,
			input logic [15:0] hold, input logic [15:0] tmo);
		write_reg(tsqa_pkg::REG_RELEASE, 32'(rel));
		write_reg(tsqa_pkg::REG_MIN, 32'(mn));
		write_reg(tsqa_pkg::REG_HOLD, 32'(hold));
		write_reg(tsqa_pkg::REG_TIMEOUT, 32'(tmo));
	endtask

	// block until everything sent is answered, then let in-flight work drain
	task automatic settle();
		while (poll_backlog.size() != 0 || s_tvalid || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic void push_req(input logic action, input logic touched,
			input logic [15:0] x, input logic [15:0] y);
		touch_req_t rq;
		rq = '{action, touched, x, y};
		poll_backlog.push_back(rq);
		queued_count++;
	endfunction

	function automatic void push_poll(input logic touched);
		push_req(tsqa_pkg::ACTION_POLL, touched, pick_raw(), pick_raw());
	endfunction

	// one acquisition: start, clear the panel, then one or more presses with releases or a timeout
	function automatic void queue_press_run();
		int presses;
		int len;
		// stray polls, dropped while nothing is armed
		if ($urandom_range(5) == 0)
			repeat ($urandom_range(1, 2)) push_poll(1'($urandom_range(1)));
		push_req(tsqa_pkg::ACTION_START, 1'($urandom_range(1)), pick_raw(), pick_raw());
		// panel still pressed at start, must clear first
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 4)) push_poll(1'b1);
			repeat (cfg_release) push_poll(1'b0);
		end else begin
			push_poll(1'b0);
		end
		// untouched panel until the timeout fires
		if (cfg_timeout <= 300 && $urandom_range(9) == 0) begin
			repeat (cfg_timeout + 1) push_poll(1'b0);
			return;
		end
		presses = (cfg_release > 16 || cfg_min > 16) ? 1 : $urandom_range(1, 3);
		repeat (presses) begin
			case ($urandom_range(9))
				0: len = (cfg_min > 1) ? cfg_min - 1 : 1;
				1: len = $urandom_range(1, cfg_min);
				2: len = (cfg_hold != 0 && cfg_hold < 64) ? cfg_hold + 1 : cfg_min;
				default: len = cfg_min + $urandom_range(0, 4);
			endcase
			repeat (len) begin
				push_poll(1'b1);
				// contact bounce shorter than a release
				if (cfg_release > 1 && $urandom_range(15) == 0)
					repeat ($urandom_range(1, (cfg_release > 5) ? 4 : cfg_release - 1))
						push_poll(1'b0);
			end
			repeat (cfg_release + (($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0))
				push_poll(1'b0);
		end
	endfunction

	task automatic run_random(input logic [7:0] rel, input logic [7:0] mn,
			input logic [15:0] hold, input logic [15:0] tmo, input int unsigned budget);
		apply_settings(rel, mn, hold, tmo);
		queued_count = 0;
		while (queued_count < budget)
			queue_press_run();
		settle();
	endtask

	// stimulus sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		read_reg(tsqa_pkg::REG_RELEASE, 32'(tsqa_pkg::RELEASE_RST));
		read_reg(tsqa_pkg::REG_MIN, 32'(tsqa_pkg::MIN_RST));
		read_reg(tsqa_pkg::REG_HOLD, 32'(tsqa_pkg::HOLD_RST));
		read_reg(tsqa_pkg::REG_TIMEOUT, 32'(tsqa_pkg::TIMEOUT_RST));

		// directed: release 1, two samples, hold at 3, timeout at 8
		apply_settings(8'd1, 8'd2, 16'd3, 16'd8);
		push_poll(1'b1);
		push_req(tsqa_pkg::ACTION_START, 1'b0, 16'h0000, 16'h0000);
		push_poll(1'b1);
		push_poll(1'b0);
		push_req(tsqa_pkg::ACTION_POLL, 1'b1, 16'hFFFF, 16'h0000);
		push_poll(1'b0);
		push_req(tsqa_pkg::ACTION_POLL, 1'b1, 16'hFFFF, 16'h0000);
		push_req(tsqa_pkg::ACTION_POLL, 1'b1, 16'h0000, 16'hFFFF);
		push_poll(1'b0);
		push_req(tsqa_pkg::ACTION_START, 1'b1, 16'hFFFF, 16'hFFFF);
		push_poll(1'b0);
		repeat (4) push_poll(1'b1);
		push_req(tsqa_pkg::ACTION_START, 1'b0, 16'h0000, 16'h0000);
		repeat (9) push_poll(1'b0);
		settle();

		run_random(tsqa_pkg::RELEASE_RST, tsqa_pkg::MIN_RST, tsqa_pkg::HOLD_RST,
			tsqa_pkg::TIMEOUT_RST, 300);
		run_random(8'd1, 8'd1, 16'd0, 16'hFFFF, 250);
		run_random(8'd255, 8'd4, 16'd0, 16'hFFFF, 260);
		run_random(8'd3, 8'd255, 16'd300, 16'hFFFF, 260);
		run_random(8'd2, 8'd3, 16'hFFFF, 16'd1, 60);
		repeat (2)
			run_random(8'($urandom_range(1, 8)), 8'($urandom_range(1, 12)),
				($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(5, 40)),
				16'($urandom_range(20, 200)), 100);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
